/* sv/ordered_array_insert_erase_find_core_defines.svh */
// Assertion macros for the ordered array core checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef ORDERED_ARRAY_INSERT_ERASE_FIND_CORE_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_ERASE_FIND_CORE_DEFINES_SVH

// General clocked property, disabled while in reset.
`define OAIEF_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must hold whenever a qualifier is high.
`define OAIEF_ASSERT_WHEN(label, qual, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (qual) |-> (cond)) else $error(msg);

`endif

/* sv/oaief_pkg.sv */
// Shared constants and types for the ordered array core.
// No dependencies; used by every other file of the block but the macro header.
package oaief_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DROP   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ERASE  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture an accepted request, restart the scan
    logic scan_inc;  // advance the find scan by one entry
    logic commit;    // update the array and load the result register
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic done;      // the pending request can complete this cycle
  } dp_stat_t;

endpackage

/* sv/oaief_if.sv */
// Request and response channel interfaces for the ordered array core.
// Depends on oaief_pkg for field widths.
interface oaief_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [oaief_pkg::OPCODE_W-1:0]       opcode;
  logic [oaief_pkg::POS_W-1:0]          position;
  logic signed [oaief_pkg::VALUE_W-1:0] value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface oaief_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [oaief_pkg::STATUS_W-1:0]  status;
  logic                            found;
  logic [oaief_pkg::INDEX_W-1:0]   match_index;
  logic [oaief_pkg::COUNT_W-1:0]   entry_count;

  modport source (output valid, status, found, match_index, entry_count, input ready);
  modport sink   (input valid, status, found, match_index, entry_count, output ready);
endinterface

/* sv/oaief_ctrl.sv */
// Controller of the ordered array core: request intake, sequencing, response valid.
// Depends on oaief_pkg for the command and status structs.
module oaief_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output oaief_pkg::ctrl_cmd_t cmd,
  input  oaief_pkg::dp_stat_t  st
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        if (st.done) begin
          // hold until the result register can take the response
          if (slot_free) begin
            cmd.commit     = 1'b1;
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* sv/oaief_dp.sv */
// Datapath of the ordered array core: entry row, fill count, find scan, result register.
// Depends on oaief_pkg for widths, opcodes, status codes and command structs.
module oaief_dp #(
  parameter int DEPTH = oaief_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  oaief_pkg::ctrl_cmd_t                 cmd,
  output oaief_pkg::dp_stat_t                  st,
  input  logic [oaief_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [oaief_pkg::POS_W-1:0]          in_position,
  input  logic signed [oaief_pkg::VALUE_W-1:0] in_value,
  output logic [oaief_pkg::STATUS_W-1:0]       status,
  output logic                                 found,
  output logic [oaief_pkg::INDEX_W-1:0]        match_index,
  output logic [oaief_pkg::COUNT_W-1:0]        entry_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > oaief_pkg::POS_W) ? CNT_W : oaief_pkg::POS_W;

  logic signed [oaief_pkg::VALUE_W-1:0] entries [DEPTH];
  logic [CNT_W-1:0]                     count;
  logic [CNT_W-1:0]                     count_next;
  logic [IDX_W-1:0]                     scan;

  logic [oaief_pkg::OPCODE_W-1:0]       op_q;
  logic [oaief_pkg::POS_W-1:0]          pos_q;
  logic signed [oaief_pkg::VALUE_W-1:0] val_q;

  logic [oaief_pkg::STATUS_W-1:0] status_c;
  logic                           grow, shrink, is_find, hit, scan_last;
  logic                           full, empty;
  logic [CMP_W-1:0]               pos_x, cnt_x, ins_x;

  always_comb begin
    full     = (count == CNT_W'(DEPTH));
    empty    = (count == '0);
    pos_x    = CMP_W'(pos_q);
    cnt_x    = CMP_W'(count);
    status_c = oaief_pkg::ST_OK;
    grow     = 1'b0;
    shrink   = 1'b0;
    case (op_q)
      oaief_pkg::OP_APPEND: begin
        if (full) status_c = oaief_pkg::ST_FULL;
        else      grow     = 1'b1;
      end
      oaief_pkg::OP_DROP: begin
        if (empty) status_c = oaief_pkg::ST_EMPTY;
        else       shrink   = 1'b1;
      end
      oaief_pkg::OP_INSERT: begin
        if (full)               status_c = oaief_pkg::ST_FULL;
        else if (pos_x > cnt_x) status_c = oaief_pkg::ST_BADPOS;
        else                    grow     = 1'b1;
      end
      oaief_pkg::OP_ERASE: begin
        if (empty)               status_c = oaief_pkg::ST_EMPTY;
        else if (pos_x >= cnt_x) status_c = oaief_pkg::ST_BADPOS;
        else                     shrink   = 1'b1;
      end
      default: begin
      end
    endcase

    // append is an insert at the current end
    ins_x = (op_q == oaief_pkg::OP_APPEND) ? cnt_x : pos_x;

    count_next = count;
    if (grow)        count_next = count + CNT_W'(1);
    else if (shrink) count_next = count - CNT_W'(1);

    is_find   = (op_q == oaief_pkg::OP_FIND);
    hit       = is_find && (CNT_W'(scan) < count) && (entries[scan] == val_q);
    scan_last = (CNT_W'(scan) + CNT_W'(1)) >= count;
    st.done   = !is_find || hit || scan_last;
  end

  // Entry row: each slot takes its own value, its lower or upper neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    localparam logic [CMP_W-1:0] SlotIdx = CMP_W'(i);
    logic signed [oaief_pkg::VALUE_W-1:0] below, above;

    if (i == 0) begin : g_lo
      assign below = entries[i];
    end else begin : g_lo
      assign below = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign above = entries[i];
    end else begin : g_hi
      assign above = entries[i+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.commit && grow) begin
        if (SlotIdx == ins_x)     entries[i] <= val_q;
        else if (SlotIdx > ins_x) entries[i] <= below;
      end else if (cmd.commit && shrink && (op_q == oaief_pkg::OP_ERASE) &&
                   (SlotIdx >= pos_x)) begin
        entries[i] <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_opcode;
      pos_q <= in_position;
      val_q <= in_value;
      scan  <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status      <= status_c;
      found       <= hit;
      match_index <= hit ? oaief_pkg::INDEX_W'(scan) : '0;
      entry_count <= oaief_pkg::COUNT_W'(count_next);
    end
  end

endmodule

/* sv/ordered_array_insert_erase_find_core.sv */
// Top level of the ordered array core: channels, controller and datapath.
// Depends on oaief_pkg, oaief_if, oaief_ctrl and oaief_dp.
//
//   channel | dir | fields                                    | accepted when
//   --------+-----+-------------------------------------------+---------------------
//   req     | in  | opcode[3] position[5] value[32] signed    | req.valid & req.ready
//   rsp     | out | status[2] found match_index[4] count[5]   | rsp.valid & rsp.ready
//
// One request at a time. Append, drop, insert and erase are captured, then
// executed in the entry row. Find is captured, then one comparator scans the row
// one entry per cycle until it hits a match or reaches the last live entry.
// Reset clears the fill count and the controller; entry contents are left as is.
// A stalled response holds in the result register; the next request is still
// accepted and waits at completion until that register is taken.
module ordered_array_insert_erase_find_core #(
  parameter int DEPTH = oaief_pkg::DEPTH_DEF
) (
  input logic           clk,
  input logic           rst,
  oaief_req_if.sink     req,
  oaief_rsp_if.source   rsp
);

  oaief_pkg::ctrl_cmd_t cmd;
  oaief_pkg::dp_stat_t  st;

  // Sequence each request: accept, scan if needed, commit into the result register.
  oaief_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .st        (st)
  );

  // Hold the entries, shift them on insert and erase, scan them on find.
  oaief_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_opcode   (req.opcode),
    .in_position (req.position),
    .in_value    (req.value),
    .status      (rsp.status),
    .found       (rsp.found),
    .match_index (rsp.match_index),
    .entry_count (rsp.entry_count)
  );

endmodule

/* sv/oaief_checker.sv */
// Port-level checker for the ordered array core, bound to the top level.
// Depends on oaief_pkg and the assertion macro header.
`include "ordered_array_insert_erase_find_core_defines.svh"

module oaief_checker #(
  parameter int DEPTH = oaief_pkg::DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [oaief_pkg::STATUS_W-1:0]  rsp_status,
  input logic                            rsp_found,
  input logic [oaief_pkg::INDEX_W-1:0]   rsp_match_index,
  input logic [oaief_pkg::COUNT_W-1:0]   rsp_entry_count
);

  localparam logic [oaief_pkg::COUNT_W-1:0] FullCount = oaief_pkg::COUNT_W'(DEPTH);

  // A stalled response keeps its content.
  `OAIEF_ASSERT_CLK(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_found) && $stable(rsp_match_index) && $stable(rsp_entry_count)), "response changed while stalled")

  // A match is only reported with an ok status.
  `OAIEF_ASSERT_WHEN(a_found_ok, rsp_valid && rsp_found, rsp_status == oaief_pkg::ST_OK, "found with non-ok status")

  // Without a match the index reads zero.
  `OAIEF_ASSERT_WHEN(a_miss_idx, rsp_valid && !rsp_found, rsp_match_index == '0, "index set without a match")

  // A full status only comes back from a full array.
  `OAIEF_ASSERT_WHEN(a_full_cnt, rsp_valid && (rsp_status == oaief_pkg::ST_FULL), rsp_entry_count == FullCount, "full status with spare room")

endmodule

bind ordered_array_insert_erase_find_core oaief_checker #(
  .DEPTH (DEPTH)
) u_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_found       (rsp.found),
  .rsp_match_index (rsp.match_index),
  .rsp_entry_count (rsp.entry_count)
);

/* test/oaief_array_checker.sv */
// Checker for the ordered array core: watches the request and response channels.
// Predicts every response from its own copy of the entry row and compares it.
// Depends on oaief_pkg and the channel interfaces in oaief_if.
module oaief_array_checker
  import oaief_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  oaief_req_if        req,
  oaief_rsp_if        rsp,
  output int          mismatches,
  output int          awaited,
  output int          level
);

  localparam int DEPTH      = DEPTH_DEF;
  localparam int WORD_IDX_W = $clog2(DEPTH);
  localparam int RING_DEPTH = 8;
  localparam int RING_W     = 3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [INDEX_W-1:0]  match_index;
    logic [COUNT_W-1:0]  entry_count;
  } reply_t;

  logic signed [VALUE_W-1:0] words [DEPTH];
  int                        fill;

  // Expected responses in request order.
  reply_t                    ring [RING_DEPTH];
  logic [RING_W-1:0]         ring_head;
  logic [RING_W-1:0]         ring_tail;
  int                        ring_used;

  initial begin
    mismatches = 0;
    awaited    = 0;
    level      = 0;
    fill       = 0;
    ring_head  = '0;
    ring_tail  = '0;
    ring_used  = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch %0d at %0t: %s got %0d want %0d", mismatches, $realtime, what, got,
             want);
  endtask

  // Apply one request to the shadow row and return the response it must produce.
  function automatic reply_t apply_request(input logic [OPCODE_W-1:0] op,
                                           input logic [POS_W-1:0] pos,
                                           input logic signed [VALUE_W-1:0] val);
    reply_t r;
    int     i;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          words[WORD_IDX_W'(fill)] = val;
          fill++;
        end
      end
      OP_DROP: begin
        if (fill == 0) r.status = ST_EMPTY;
        else fill--;
      end
      OP_INSERT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else if (int'(pos) > fill) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = fill; i > int'(pos); i--)
            words[WORD_IDX_W'(i)] = words[WORD_IDX_W'(i-1)];
          words[WORD_IDX_W'(pos)] = val;
          fill++;
        end
      end
      OP_ERASE: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= fill) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = int'(pos); i + 1 < fill; i++)
            words[WORD_IDX_W'(i)] = words[WORD_IDX_W'(i+1)];
          fill--;
        end
      end
      OP_FIND: begin
        for (i = 0; i < fill && !r.found; i++) begin
          if (words[WORD_IDX_W'(i)] == val) begin
            r.found       = 1'b1;
            r.match_index = INDEX_W'(i);
          end
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_W'(fill);
    return r;
  endfunction

  // Retire the response first: it always belongs to an earlier request.
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (ring_used == 0) begin
          report_mismatch("response with nothing awaited, status", int'(rsp.status), -1);
        end else begin
          want = ring[ring_head];
          ring_head++;
          ring_used--;
          if (rsp.status !== want.status)
            report_mismatch("status", int'(rsp.status), int'(want.status));
          if (rsp.found !== want.found)
            report_mismatch("found", int'(rsp.found), int'(want.found));
          if (rsp.match_index !== want.match_index)
            report_mismatch("match_index", int'(rsp.match_index), int'(want.match_index));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch("entry_count", int'(rsp.entry_count), int'(want.entry_count));
        end
      end
      if (req.valid && req.ready) begin
        if (ring_used == RING_DEPTH) begin
          report_mismatch("requests awaiting a response", ring_used, RING_DEPTH);
        end else begin
          ring[ring_tail] = apply_request(req.opcode, req.position, req.value);
          ring_tail++;
          ring_used++;
        end
      end
    end
    awaited <= ring_used;
    level   <= fill;
  end

endmodule

/* test/tb_top.sv */
// Testbench top for the ordered array core: clock, reset, stimulus and verdict.
// Depends on oaief_pkg, oaief_if, the core itself and oaief_array_checker.
module tb_top;
  import oaief_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int MAX_CYCLES = 200000;
  localparam int MAX_IDLE   = 5;

  localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   mismatches;
  int   awaited;
  int   level;
  bit   calm = 1'b0;  // while set, neither side inserts idle cycles

  oaief_req_if req ();
  oaief_rsp_if rsp ();

  always #6 clk = ~clk;

  ordered_array_insert_erase_find_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  oaief_array_checker array_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .awaited    (awaited),
    .level      (level)
  );

  // Hold off a random number of cycles, then present one request and hold it
  // until the core takes it. Valid stays high on return so back-to-back
  // requests need no extra cycle.
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.opcode   <= op;
    req.position <= pos;
    req.value    <= val;
    do @(posedge clk); while (!req.ready);
  endtask

  // Drop valid and stall until every awaited response has come back.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Mostly a small pool so finds hit and duplicates occur; sometimes any word.
  function automatic logic signed [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return WORD_MIN;
      3:       return WORD_MAX;
      default: return VALUE_W'($signed($urandom_range(0, 5)) - 2);
    endcase
  endfunction

  // Mostly positions near the live range, sometimes anything the field allows.
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    return POS_W'($urandom_range(0, level));
  endfunction

  // Weight the opcode mix: grow phases fill the row, shrink phases drain it.
  function automatic logic [OPCODE_W-1:0] pick_opcode(input int kind);
    int roll;
    roll = $urandom_range(0, 99);
    case (kind)
      0: begin
        if (roll < 40) return OP_APPEND;
        if (roll < 70) return OP_INSERT;
        if (roll < 80) return OP_FIND;
        if (roll < 88) return OP_DROP;
        if (roll < 96) return OP_ERASE;
      end
      1: begin
        if (roll < 10) return OP_APPEND;
        if (roll < 20) return OP_INSERT;
        if (roll < 35) return OP_FIND;
        if (roll < 65) return OP_DROP;
        if (roll < 95) return OP_ERASE;
      end
      default: begin
        if (roll < 20) return OP_APPEND;
        if (roll < 40) return OP_INSERT;
        if (roll < 65) return OP_FIND;
        if (roll < 80) return OP_DROP;
        if (roll < 97) return OP_ERASE;
      end
    endcase
    // unused codes above find: the core must do nothing
    return OP_FIND + OPCODE_W'($urandom_range(1, 3));
  endfunction

  // Response side: stall a random number of cycles per response, then take it.
  initial begin
    int stall;
    rsp.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  // Watchdog: fail the run if it has not finished by MAX_CYCLES, as when the core stops making progress.
  initial begin
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic signed [VALUE_W-1:0] last_word;
    int                        kind;
    req.valid    = 1'b0;
    req.opcode   = OP_FIND;
    req.position = '0;
    req.value    = '0;
    rst          = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-row corner cases first.
    send_request(OP_DROP, 0, 0);
    send_request(OP_ERASE, 31, 0);    // empty wins over a bad position
    send_request(OP_FIND, 0, 0);
    send_request(OP_INSERT, 1, 5);    // past the end of an empty row
    // Build MIN, -1, MAX, 0, -1 using every way of adding a word.
    send_request(OP_INSERT, 0, WORD_MIN);
    send_request(OP_APPEND, 31, WORD_MAX);
    send_request(OP_INSERT, 1, -1);
    send_request(OP_INSERT, 3, 0);    // position equal to the count appends
    send_request(OP_APPEND, 0, -1);
    // Finds: duplicate returns the lowest index, first entry, middle, no match.
    send_request(OP_FIND, 0, -1);
    send_request(OP_FIND, 31, WORD_MIN);
    send_request(OP_FIND, 0, 0);
    send_request(OP_FIND, 0, 12345);
    // Bad positions leave the row alone.
    send_request(OP_ERASE, 31, 0);
    send_request(OP_ERASE, 5, 0);
    send_request(OP_INSERT, 31, 7);
    // Erase the first and the last entry.
    send_request(OP_ERASE, 0, 0);
    send_request(OP_ERASE, 3, 0);
    // Unused opcodes.
    send_request(OP_FIND + OPCODE_W'(1), 31, -1);
    send_request(OP_FIND + OPCODE_W'(2), 0, WORD_MAX);
    send_request(OP_FIND + OPCODE_W'(3), 17, WORD_MIN);
    send_request(OP_DROP, 0, 0);
    settle();

    // Fill to capacity, hit every full case, search for the top slot's word, drain to empty.
    last_word = 0;
    repeat (DEPTH - 2) begin
      last_word = pick_word();
      send_request(OP_APPEND, pick_position(), last_word);
    end
    send_request(OP_APPEND, 0, 1);
    send_request(OP_INSERT, 31, 1);   // full wins over a bad position
    send_request(OP_INSERT, 0, 1);
    send_request(OP_FIND, 0, last_word);
    repeat (DEPTH + 1) send_request(OP_DROP, pick_position(), pick_word());
    settle();

    // Random phases: alternate grow, shrink and mixed traffic; some phases run
    // without idle cycles, and every fourth one ends by waiting out every awaited response.
    for (int phase = 0; phase < 15; phase++) begin
      kind = phase % 3;
      calm = ($urandom_range(0, 3) == 0);
      repeat (38) send_request(pick_opcode(kind), pick_position(), pick_word());
      if (phase % 4 == 3) settle();
    end
    calm = 1'b0;

    // Wait out every response, then idle for stray traffic before the verdict.
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
